// ----- rtl/core/ungapped_kmer_diagonal_aligner_defines.svh -----
// Assertion macros used by the aligner checker.
`ifndef UNGAPPED_KMER_DIAGONAL_ALIGNER_DEFINES_SVH
`define UNGAPPED_KMER_DIAGONAL_ALIGNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UKDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define UKDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ukda_pkg.sv -----
// Shared constants and types of the ungapped k-mer diagonal aligner.
package ukda_pkg;

	localparam int MAX_LEN   = 8;
	localparam int SYM_W     = 8;
	localparam int LEN_W     = 4;
	localparam int IDX_W     = $clog2(MAX_LEN);
	localparam int SCORE_W   = 6;
	localparam int RUN_W     = 4;
	localparam int SEQ_W     = MAX_LEN * SYM_W;
	localparam int S_TDATA_W = 2 * (SEQ_W + LEN_W);
	localparam int M_TDATA_W = SCORE_W + RUN_W + 2 * IDX_W;
	localparam int CAND_N    = 2 * MAX_LEN - 1;
	localparam int TREE_LVL  = $clog2(CAND_N);
	localparam int TREE_N    = 1 << TREE_LVL;

	typedef struct packed {
		logic                      vld;
		logic signed [SCORE_W-1:0] score;
		logic [RUN_W-1:0]          run;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
	} cand_t;

endpackage

// ----- rtl/core/ukda_grid.sv -----
// Match grid, per-diagonal score/run chains and end-cell extraction.
module ukda_grid (
	input  logic [ukda_pkg::SEQ_W-1:0]  ref_symbols,
	input  logic [ukda_pkg::LEN_W-1:0]  ref_length,
	input  logic [ukda_pkg::SEQ_W-1:0]  query_symbols,
	input  logic [ukda_pkg::LEN_W-1:0]  query_length,
	output ukda_pkg::cand_t [ukda_pkg::CAND_N-1:0] cand
);

	logic signed [ukda_pkg::SCORE_W-1:0] sc [ukda_pkg::MAX_LEN][ukda_pkg::MAX_LEN];
	logic [ukda_pkg::RUN_W-1:0]          cr [ukda_pkg::MAX_LEN][ukda_pkg::MAX_LEN];
	logic [ukda_pkg::RUN_W-1:0]          lg [ukda_pkg::MAX_LEN][ukda_pkg::MAX_LEN];
	logic [ukda_pkg::LEN_W-1:0]          rl;
	logic [ukda_pkg::LEN_W-1:0]          ql;
	logic [ukda_pkg::IDX_W-1:0]          ri;
	logic [ukda_pkg::IDX_W-1:0]          qi;

	always_comb begin
		rl = (ref_length > ukda_pkg::LEN_W'(ukda_pkg::MAX_LEN)) ?
			ukda_pkg::LEN_W'(ukda_pkg::MAX_LEN) : ref_length;
		ql = (query_length > ukda_pkg::LEN_W'(ukda_pkg::MAX_LEN)) ?
			ukda_pkg::LEN_W'(ukda_pkg::MAX_LEN) : query_length;
		ri = ukda_pkg::IDX_W'(rl - ukda_pkg::LEN_W'(1));
		qi = ukda_pkg::IDX_W'(ql - ukda_pkg::LEN_W'(1));
	end

	// cell (i,j) extends (i-1,j-1); the chain along a diagonal is at most MAX_LEN deep
	always_comb begin
		logic mt;
		mt = 1'b0;
		for (int i = 0; i < ukda_pkg::MAX_LEN; i++) begin
			for (int j = 0; j < ukda_pkg::MAX_LEN; j++) begin
				mt = ref_symbols[i*ukda_pkg::SYM_W +: ukda_pkg::SYM_W] ==
					query_symbols[j*ukda_pkg::SYM_W +: ukda_pkg::SYM_W];
				if (i == 0 || j == 0) begin
					sc[i][j] = mt ? ukda_pkg::SCORE_W'(2) : '0;
					cr[i][j] = mt ? ukda_pkg::RUN_W'(1) : '0;
					lg[i][j] = mt ? ukda_pkg::RUN_W'(1) : '0;
				end else if (mt) begin
					sc[i][j] = sc[i-1][j-1] + ukda_pkg::SCORE_W'(2);
					cr[i][j] = cr[i-1][j-1] + ukda_pkg::RUN_W'(1);
					lg[i][j] = (cr[i-1][j-1] + ukda_pkg::RUN_W'(1) > lg[i-1][j-1]) ?
						cr[i-1][j-1] + ukda_pkg::RUN_W'(1) : lg[i-1][j-1];
				end else begin
					sc[i][j] = sc[i-1][j-1] - ukda_pkg::SCORE_W'(1);
					cr[i][j] = '0;
					lg[i][j] = lg[i-1][j-1];
				end
			end
		end
	end

	// row-major end-cell order: last column above the last row, then the last row
	always_comb begin
		for (int k = 0; k < ukda_pkg::MAX_LEN - 1; k++) begin
			cand[k].vld   = (ql != '0) && (ukda_pkg::LEN_W'(k + 1) < rl);
			cand[k].score = sc[k][qi];
			cand[k].run   = lg[k][qi];
			cand[k].row   = ukda_pkg::IDX_W'(k);
			cand[k].col   = qi;
		end
		for (int j = 0; j < ukda_pkg::MAX_LEN; j++) begin
			cand[ukda_pkg::MAX_LEN-1+j].vld   = (rl != '0) && (ukda_pkg::LEN_W'(j) < ql);
			cand[ukda_pkg::MAX_LEN-1+j].score = sc[ri][j];
			cand[ukda_pkg::MAX_LEN-1+j].run   = lg[ri][j];
			cand[ukda_pkg::MAX_LEN-1+j].row   = ri;
			cand[ukda_pkg::MAX_LEN-1+j].col   = ukda_pkg::IDX_W'(j);
		end
	end

endmodule

// ----- rtl/core/ukda_pick.sv -----
// First-best end-cell selection tree and result formatting.
module ukda_pick (
	input  ukda_pkg::cand_t [ukda_pkg::CAND_N-1:0] cand,
	output logic [ukda_pkg::M_TDATA_W-1:0]          res_data,
	output logic                                    res_found
);

	ukda_pkg::cand_t tr [ukda_pkg::TREE_LVL+1][ukda_pkg::TREE_N];
	ukda_pkg::cand_t best;

	// a is earlier in visit order; b takes over only when strictly better
	function automatic ukda_pkg::cand_t pick_later(ukda_pkg::cand_t a, ukda_pkg::cand_t b);
		ukda_pkg::cand_t r;
		r = a;
		if (!a.vld) begin
			r = b;
		end else if (b.vld && (b.score > a.score ||
				(b.score == a.score && b.run > a.run))) begin
			r = b;
		end
		return r;
	endfunction

	always_comb begin
		tr = '{default: '0};
		for (int k = 0; k < ukda_pkg::CAND_N; k++) begin
			tr[0][k] = cand[k];
		end
		for (int l = 0; l < ukda_pkg::TREE_LVL; l++) begin
			for (int k = 0; k < (ukda_pkg::TREE_N >> (l + 1)); k++) begin
				tr[l+1][k] = pick_later(tr[l][2*k], tr[l][2*k+1]);
			end
		end
		best = tr[ukda_pkg::TREE_LVL][0];
	end

	always_comb begin
		res_found = best.vld && (best.score > ukda_pkg::SCORE_W'(0) ||
			(best.score == ukda_pkg::SCORE_W'(0) && best.run != '0));
		res_data  = res_found ? {best.col, best.row, best.run, best.score} : '0;
	end

endmodule

// ----- rtl/core/ungapped_kmer_diagonal_aligner.sv -----
// Ungapped k-mer diagonal aligner: top level with stream ports and pipeline.
//
// Scores every gapless diagonal of a reference/query pair of up to eight
// byte symbols and returns the best end cell (score in half units, longest
// match run, position, found flag). One item per clock unless a stalled
// output backs up the pipeline. Registers in order: input register, end-cell
// candidate register (after the eight-cell diagonal chains), result register
// (after the four-level selection tree). Each stage moves on when the stage
// after it is free, so a stalled output only backs up as far as needed.
module ungapped_kmer_diagonal_aligner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ref_symbols[63:0], ref_length[67:64], query_symbols[131:68], query_length[135:132]
	input  logic [ukda_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// score_halves[5:0], longest_run[9:6], end_row[12:10], end_col[15:13]
	output logic [ukda_pkg::M_TDATA_W-1:0]    m_tdata,
	// found[0]
	output logic [0:0]                        m_tuser
);

	localparam int RL_LO = ukda_pkg::SEQ_W;
	localparam int QS_LO = ukda_pkg::SEQ_W + ukda_pkg::LEN_W;
	localparam int QL_LO = 2 * ukda_pkg::SEQ_W + ukda_pkg::LEN_W;

	logic                                   v_s1;
	logic                                   v_s2;
	logic                                   m_valid_q;
	logic                                   rdy1;
	logic                                   rdy2;
	logic                                   rdy3;
	logic [ukda_pkg::S_TDATA_W-1:0]         data_s1;
	ukda_pkg::cand_t [ukda_pkg::CAND_N-1:0] cand;
	ukda_pkg::cand_t [ukda_pkg::CAND_N-1:0] cand_s2;
	logic [ukda_pkg::M_TDATA_W-1:0]         res_data;
	logic                                   res_found;
	logic [ukda_pkg::M_TDATA_W-1:0]         res_data_q;
	logic                                   res_found_q;

	assign rdy3     = !m_valid_q || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_data_q;
	assign m_tuser  = res_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) m_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) data_s1 <= s_tdata;
		if (rdy2 && v_s1) cand_s2 <= cand;
		if (rdy3 && v_s2) begin
			res_data_q  <= res_data;
			res_found_q <= res_found;
		end
	end

	ukda_grid u_grid (
		.ref_symbols   (data_s1[RL_LO-1:0]),
		.ref_length    (data_s1[QS_LO-1:RL_LO]),
		.query_symbols (data_s1[QL_LO-1:QS_LO]),
		.query_length  (data_s1[ukda_pkg::S_TDATA_W-1:QL_LO]),
		.cand          (cand)
	);

	ukda_pick u_pick (
		.cand      (cand_s2),
		.res_data  (res_data),
		.res_found (res_found)
	);

endmodule

// ----- rtl/core/ukda_checker.sv -----
// Port-level checker for the aligner, bound to the top level.
`include "ungapped_kmer_diagonal_aligner_defines.svh"

module ukda_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ukda_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);

	`UKDA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
	`UKDA_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed under stall")
	`UKDA_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input stalled with empty output")
	`UKDA_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "nonzero fields without a hit")
	`UKDA_ASSERT_NOW(a_hit_positive, m_tvalid && m_tuser[0], !m_tdata[5] && (m_tdata[5:0] != 6'd0 || m_tdata[9:6] != 4'd0), "hit does not beat zero")

endmodule

bind ungapped_kmer_diagonal_aligner ukda_checker u_ukda_checker (.*);
